// ===== hdl/dbst_pkg.sv =====
// shared types and constants for the double-buffered slot timer bank
package dbst_pkg;

    localparam int NUM_SETS      = 16;
    localparam int SLOTS_PER_SET = 16;
    localparam int DEPTH         = NUM_SETS * SLOTS_PER_SET;
    localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W         = $clog2(SLOTS_PER_SET + 1);

    localparam int DATA_W        = 32;
    localparam int CFG_W         = 5;
    localparam int CFG_IDX_W     = 1;
    localparam logic [CFG_W-1:0] WALK_COUNT_RESET = 5'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALK_COUNT = 1'b1;

    typedef enum logic [2:0] {
        KIND_BEGIN     = 3'd0,
        KIND_END       = 3'd1,
        KIND_SET       = 3'd2,
        KIND_READ_LAST = 3'd3,
        KIND_RESET_ONE = 3'd4,
        KIND_RESET_ALL = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WALK
    } state_t;

    typedef struct packed {
        logic              toggle;
        logic [DATA_W-1:0] stamp;
        logic [DATA_W-1:0] acc1;
        logic [DATA_W-1:0] acc0;
    } slot_word_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic walk_step;
        logic clear_step;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic start_walk;
        logic walk_last;
        logic result_blocked;
    } status_t;

endpackage

// ===== hdl/dbst_ctrl.sv =====
// controller state machine: clearing pass, item execution and reset-all walk
module dbst_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  dbst_pkg::status_t status,
    output dbst_pkg::cmd_t   cmd,
    output logic             busy
);

    dbst_pkg::state_t state_reg;
    dbst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dbst_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            dbst_pkg::S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = dbst_pkg::S_IDLE;
                end
            end
            dbst_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.start_walk ? dbst_pkg::S_WALK : dbst_pkg::S_EXEC;
                end
            end
            dbst_pkg::S_EXEC:
            begin
                if (!status.result_blocked)
                begin
                    cmd.exec   = 1'b1;
                    state_next = dbst_pkg::S_IDLE;
                end
            end
            dbst_pkg::S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = dbst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dbst_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/dbst_datapath.sv =====
// datapath: slot memory, item registers, read-modify-write logic and output register
module dbst_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dbst_pkg::cmd_t                cmd,
    output dbst_pkg::status_t             status,
    input  logic [2:0]                    kind,
    input  logic [3:0]                    set_index,
    input  logic [3:0]                    slot_index,
    input  logic [31:0]                   now_us,
    input  logic signed [31:0]            write_value,
    input  logic                          enabled,
    input  logic [dbst_pkg::CFG_W-1:0]    walk_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            read_value
);

    dbst_pkg::slot_word_t mem [dbst_pkg::DEPTH];
    dbst_pkg::slot_word_t rd_data_reg;

    dbst_pkg::kind_t                   kind_reg;
    logic [dbst_pkg::ADDR_W-1:0]       pos_reg;
    logic                              hit_reg;
    logic [dbst_pkg::DATA_W-1:0]       now_reg;
    logic [dbst_pkg::DATA_W-1:0]       wval_reg;

    logic [dbst_pkg::CNT_W-1:0]        walk_idx_reg;
    logic [dbst_pkg::CNT_W-1:0]        walk_idx_next;
    logic [dbst_pkg::ADDR_W-1:0]       clear_idx_reg;

    logic                              out_valid_reg;
    logic signed [dbst_pkg::DATA_W-1:0] read_value_reg;

    logic [31:0]                       pos_wide;
    logic                              hit;
    logic [dbst_pkg::ADDR_W-1:0]       pos;
    logic [dbst_pkg::CNT_W-1:0]        count_sat;
    dbst_pkg::kind_t                   in_kind;

    logic [dbst_pkg::DATA_W-1:0]       act_val;
    logic [dbst_pkg::DATA_W-1:0]       inact_val;
    logic [dbst_pkg::DATA_W-1:0]       sum_val;
    dbst_pkg::slot_word_t              exec_word;
    logic                              exec_wr;
    logic [dbst_pkg::DATA_W-1:0]       exec_res;
    logic                              need_result;

    logic                              mem_we;
    logic [dbst_pkg::ADDR_W-1:0]       mem_wa;
    dbst_pkg::slot_word_t              mem_wd;
    logic                              mem_re;
    logic [dbst_pkg::ADDR_W-1:0]       mem_ra;

    function automatic dbst_pkg::slot_word_t flip_clear(input dbst_pkg::slot_word_t w);
        dbst_pkg::slot_word_t r;
        r        = w;
        r.toggle = ~w.toggle;
        if (w.toggle)
        begin
            r.acc1 = '0;
        end
        else
        begin
            r.acc0 = '0;
        end
        return r;
    endfunction

    // slot address decode and walk count saturation
    always_comb
    begin
        in_kind  = dbst_pkg::kind_t'(kind);
        pos_wide = 32'(set_index) * 32'(dbst_pkg::SLOTS_PER_SET) + 32'(slot_index);
        hit      = (32'(set_index) < 32'(dbst_pkg::NUM_SETS))
                && (32'(slot_index) < 32'(dbst_pkg::SLOTS_PER_SET));
        pos      = hit ? dbst_pkg::ADDR_W'(pos_wide) : '0;
        if (32'(walk_count) > 32'(dbst_pkg::SLOTS_PER_SET))
        begin
            count_sat = dbst_pkg::CNT_W'(dbst_pkg::SLOTS_PER_SET);
        end
        else
        begin
            count_sat = dbst_pkg::CNT_W'(walk_count);
        end
    end

    assign walk_idx_next = walk_idx_reg + 1'b1;
    assign need_result   = (kind_reg == dbst_pkg::KIND_END)
                        || (kind_reg == dbst_pkg::KIND_READ_LAST);

    assign status.clear_last     = (clear_idx_reg == dbst_pkg::ADDR_W'(dbst_pkg::DEPTH - 1));
    assign status.start_walk     = (in_kind == dbst_pkg::KIND_RESET_ALL) && enabled
                                && (count_sat != '0);
    assign status.walk_last      = (walk_idx_next == count_sat);
    assign status.result_blocked = need_result && out_valid_reg && out_stall;

    // per-item update of one slot
    always_comb
    begin
        act_val   = rd_data_reg.toggle ? rd_data_reg.acc0 : rd_data_reg.acc1;
        inact_val = rd_data_reg.toggle ? rd_data_reg.acc1 : rd_data_reg.acc0;
        sum_val   = act_val + (now_reg - rd_data_reg.stamp);
        exec_word = rd_data_reg;
        exec_wr   = 1'b0;
        exec_res  = '0;
        case (kind_reg)
            dbst_pkg::KIND_BEGIN:
            begin
                exec_word.stamp = now_reg;
                exec_wr         = 1'b1;
            end
            dbst_pkg::KIND_END:
            begin
                if (rd_data_reg.toggle)
                begin
                    exec_word.acc0 = sum_val;
                end
                else
                begin
                    exec_word.acc1 = sum_val;
                end
                exec_wr  = 1'b1;
                exec_res = (enabled && hit_reg) ? sum_val : '0;
            end
            dbst_pkg::KIND_SET:
            begin
                if (rd_data_reg.toggle)
                begin
                    exec_word.acc0 = wval_reg;
                end
                else
                begin
                    exec_word.acc1 = wval_reg;
                end
                exec_wr = 1'b1;
            end
            dbst_pkg::KIND_READ_LAST:
            begin
                exec_res = hit_reg ? inact_val : '0;
            end
            dbst_pkg::KIND_RESET_ONE:
            begin
                exec_word = flip_clear(rd_data_reg);
                exec_wr   = 1'b1;
            end
            default:
            begin
                exec_wr = 1'b0;
            end
        endcase
        if (!(enabled && hit_reg))
        begin
            exec_wr = 1'b0;
        end
    end

    // memory port selection
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = pos_reg;
        mem_wd = exec_word;
        if (cmd.clear_step)
        begin
            mem_we = 1'b1;
            mem_wa = clear_idx_reg;
            mem_wd = '0;
        end
        else if (cmd.walk_step)
        begin
            mem_we = 1'b1;
            mem_wa = dbst_pkg::ADDR_W'(walk_idx_reg);
            mem_wd = flip_clear(rd_data_reg);
        end
        else if (cmd.exec)
        begin
            mem_we = exec_wr;
        end
        mem_re = cmd.accept || cmd.walk_step;
        if (cmd.accept)
        begin
            mem_ra = status.start_walk ? '0 : pos;
        end
        else
        begin
            mem_ra = dbst_pkg::ADDR_W'(walk_idx_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= in_kind;
            pos_reg  <= pos;
            hit_reg  <= hit;
            now_reg  <= now_us;
            wval_reg <= $unsigned(write_value);
        end
        if (cmd.exec && need_result)
        begin
            read_value_reg <= $signed(exec_res);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            walk_idx_reg  <= '0;
            clear_idx_reg <= '0;
        end
        else
        begin
            if (cmd.exec && need_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.accept)
            begin
                walk_idx_reg <= '0;
            end
            else if (cmd.walk_step)
            begin
                walk_idx_reg <= walk_idx_next;
            end
            if (cmd.clear_step)
            begin
                clear_idx_reg <= clear_idx_reg + 1'b1;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;

endmodule

// ===== hdl/double_buffered_slot_timer_bank.sv =====
// top level of the double-buffered slot timer bank
// Each slot keeps a start stamp, two accumulators and a toggle bit in one word of a
// single slot memory, so every item is a read-modify-write of that memory: the item is
// taken with the slot read and applied in the exec state (update, write back, result).
// An end or read_last result waits in the output register and, if that register is
// still held by the previous result, the update waits with it. A reset_all that is
// enabled walks the first N slots of set 0, N being the walk count saturated to the
// slots per set, one slot written per cycle; with a count of zero it is handled like
// any other item. After reset the memory is cleared one slot per cycle, all 256 slots,
// while in_stall stays high; configuration writes are taken throughout.
module double_buffered_slot_timer_bank (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0]                         kind,
    input  logic [3:0]                         set_index,
    input  logic [3:0]                         slot_index,
    input  logic [31:0]                        now_us,
    input  logic signed [31:0]                 write_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [31:0]                 read_value,
    input  logic                               cfg_we,
    input  logic [dbst_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dbst_pkg::CFG_W-1:0]         cfg_data
);

    logic                        enabled_reg;
    logic [dbst_pkg::CFG_W-1:0]  walk_count_reg;
    dbst_pkg::cmd_t              cmd;
    dbst_pkg::status_t           status;
    logic                        busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            walk_count_reg <= dbst_pkg::WALK_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dbst_pkg::CFG_ENABLED:    enabled_reg    <= cfg_data[0];
                dbst_pkg::CFG_WALK_COUNT: walk_count_reg <= cfg_data;
                default:                  enabled_reg    <= enabled_reg;
            endcase
        end
    end

    dbst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    dbst_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .kind        (kind),
        .set_index   (set_index),
        .slot_index  (slot_index),
        .now_us      (now_us),
        .write_value (write_value),
        .enabled     (enabled_reg),
        .walk_count  (walk_count_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value)
    );

    assign in_stall = busy;

endmodule

// ===== hdl/dbst_checker.sv =====
// port-level checks for the slot timer bank, bound to the top level
module dbst_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [2:0]                         kind,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [31:0]                 read_value
);

    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("input taken while previous transaction in progress");

    // memory clearing holds off input right after reset
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> in_stall)
        else $error("input open during clearing pass");

    // end always answers after the exec state when output is free at acceptance
    a_end_answers: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && kind == 3'(dbst_pkg::KIND_END) && !out_valid |=> ##1 out_valid)
        else $error("end transaction gave no result");

    // begin never answers
    a_begin_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && kind == 3'(dbst_pkg::KIND_BEGIN) && !out_valid |=> ##1 !out_valid)
        else $error("begin transaction gave a result");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_value))
        else $error("stalled result changed");

endmodule

bind double_buffered_slot_timer_bank dbst_checker u_dbst_checker (.*);

// ===== tb/tb_double_buffered_slot_timer_bank.sv =====
// self-checking testbench for the double-buffered slot timer bank
module tb_double_buffered_slot_timer_bank;

    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 40;

    class slot_timer_tracker;
        logic [dbst_pkg::DATA_W-1:0] acc_zero [dbst_pkg::DEPTH];
        logic [dbst_pkg::DATA_W-1:0] acc_one [dbst_pkg::DEPTH];
        logic [dbst_pkg::DATA_W-1:0] stamp [dbst_pkg::DEPTH];
        bit                          toggle [dbst_pkg::DEPTH];
        bit                          enabled;
        logic [dbst_pkg::CFG_W-1:0]  walk_count;
        logic [dbst_pkg::DATA_W-1:0] pending_reads [$];
        int                          errors;

        function new();
            for (int i = 0; i < dbst_pkg::DEPTH; i++)
            begin
                acc_zero[i] = '0;
                acc_one[i] = '0;
                stamp[i] = '0;
                toggle[i] = 1'b0;
            end
            enabled = 1'b0;
            walk_count = dbst_pkg::WALK_COUNT_RESET;
            errors = 0;
        endfunction

        function void configure(bit en, logic [dbst_pkg::CFG_W-1:0] count);
            enabled = en;
            walk_count = count;
        endfunction

        function int outstanding();
            return pending_reads.size();
        endfunction

        function logic [dbst_pkg::DATA_W-1:0] active_acc(int pos);
            return toggle[pos] ? acc_zero[pos] : acc_one[pos];
        endfunction

        function logic [dbst_pkg::DATA_W-1:0] inactive_acc(int pos);
            return toggle[pos] ? acc_one[pos] : acc_zero[pos];
        endfunction

        function void write_active(int pos, logic [dbst_pkg::DATA_W-1:0] value);
            if (toggle[pos])
                acc_zero[pos] = value;
            else
                acc_one[pos] = value;
        endfunction

        function void flip_and_clear(int pos);
            toggle[pos] = !toggle[pos];
            write_active(pos, '0);
        endfunction

        function void note_transaction(logic [2:0] k, logic [3:0] set_idx, logic [3:0] slot_idx,
                                       logic [31:0] now, logic [31:0] wval);
            bit                          in_range;
            int                          pos;
            int                          count;
            logic [dbst_pkg::DATA_W-1:0] sum;
            in_range = (int'(set_idx) < dbst_pkg::NUM_SETS)
                    && (int'(slot_idx) < dbst_pkg::SLOTS_PER_SET);
            pos = in_range ? int'(set_idx) * dbst_pkg::SLOTS_PER_SET + int'(slot_idx) : 0;
            case (k)
                dbst_pkg::KIND_BEGIN:
                begin
                    if (enabled && in_range)
                        stamp[pos] = now;
                end
                dbst_pkg::KIND_END:
                begin
                    sum = '0;
                    if (enabled && in_range)
                    begin
                        sum = active_acc(pos) + (now - stamp[pos]);
                        write_active(pos, sum);
                    end
                    pending_reads.push_back(sum);
                end
                dbst_pkg::KIND_SET:
                begin
                    if (enabled && in_range)
                        write_active(pos, wval);
                end
                dbst_pkg::KIND_READ_LAST:
                begin
                    pending_reads.push_back(in_range ? inactive_acc(pos) : '0);
                end
                dbst_pkg::KIND_RESET_ONE:
                begin
                    if (enabled && in_range)
                        flip_and_clear(pos);
                end
                dbst_pkg::KIND_RESET_ALL:
                begin
                    if (enabled)
                    begin
                        count = (int'(walk_count) > dbst_pkg::SLOTS_PER_SET)
                                ? dbst_pkg::SLOTS_PER_SET : int'(walk_count);
                        for (int i = 0; i < count; i++)
                            flip_and_clear(i);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_read(logic [dbst_pkg::DATA_W-1:0] got);
            logic [dbst_pkg::DATA_W-1:0] want;
            if (pending_reads.size() == 0)
            begin
                $error("read_value: expected no transaction, actual %0d", $signed(got));
                errors++;
            end
            else
            begin
                want = pending_reads.pop_front();
                if (got !== want)
                begin
                    $error("read_value: expected %0d, actual %0d", $signed(want), $signed(got));
                    errors++;
                end
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic [2:0]                         kind;
    logic [3:0]                         set_index;
    logic [3:0]                         slot_index;
    logic [31:0]                        now_us;
    logic signed [31:0]                 write_value;
    logic                               out_valid;
    logic                               out_stall;
    logic signed [31:0]                 read_value;
    logic                               cfg_we;
    logic [dbst_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [dbst_pkg::CFG_W-1:0]         cfg_data;

    slot_timer_tracker timer_tracker;
    int                in_gap_rate;
    int                out_stall_rate;
    int                out_stall_left;
    int                quiet_cycles;
    logic [31:0]       free_run_us;

    double_buffered_slot_timer_bank u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .set_index   (set_index),
        .slot_index  (slot_index),
        .now_us      (now_us),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (out_stall_left != 0)
            out_stall_left = out_stall_left - 1;
        else if (int'($urandom_range(0, 15)) < out_stall_rate)
            out_stall_left = $urandom_range(1, 16);
        out_stall <= (out_stall_left != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                timer_tracker.check_read(read_value);
            if (in_valid && !in_stall)
                timer_tracker.note_transaction(kind, set_index, slot_index, now_us, write_value);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic send(logic [2:0] k, logic [3:0] set_idx, logic [3:0] slot_idx,
                        logic [31:0] now, logic [31:0] wval);
        in_valid <= 1'b1;
        kind <= k;
        set_index <= set_idx;
        slot_index <= slot_idx;
        now_us <= now;
        write_value <= wval;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (int'($urandom_range(0, 15)) < in_gap_rate)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16))
                @(posedge clk);
        end
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (timer_tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic apply_settings(bit en, logic [dbst_pkg::CFG_W-1:0] count);
        cfg_we <= 1'b1;
        cfg_index <= dbst_pkg::CFG_ENABLED;
        cfg_data <= {{(dbst_pkg::CFG_W-1){1'b0}}, en};
        @(posedge clk);
        cfg_index <= dbst_pkg::CFG_WALK_COUNT;
        cfg_data <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
        timer_tracker.configure(en, count);
    endtask

    task automatic directed_enabled();
        send(dbst_pkg::KIND_BEGIN, 4'd15, 4'd15, 32'hFFFF_FFF0, 32'h0);
        send(dbst_pkg::KIND_END, 4'd15, 4'd15, 32'h0000_0010, 32'hFFFF_FFFF);
        send(dbst_pkg::KIND_READ_LAST, 4'd15, 4'd15, 32'h0, 32'h0);
        send(dbst_pkg::KIND_RESET_ONE, 4'd15, 4'd15, 32'h0, 32'h0);
        send(dbst_pkg::KIND_READ_LAST, 4'd15, 4'd15, 32'h0, 32'h0);
        send(dbst_pkg::KIND_SET, 4'd15, 4'd15, 32'h0, 32'h7FFF_FFFF);
        send(dbst_pkg::KIND_END, 4'd15, 4'd15, 32'h0000_0011, 32'h0);
        send(dbst_pkg::KIND_SET, 4'd0, 4'd0, 32'hFFFF_FFFF, 32'h8000_0000);
        send(dbst_pkg::KIND_READ_LAST, 4'd0, 4'd0, 32'h0, 32'h0);
        send(dbst_pkg::KIND_BEGIN, 4'd0, 4'd0, 32'h0, 32'h0);
        send(dbst_pkg::KIND_END, 4'd0, 4'd0, 32'hFFFF_FFFF, 32'h0);
        send(dbst_pkg::KIND_RESET_ALL, 4'd9, 4'd3, 32'h0, 32'h0);
        send(dbst_pkg::KIND_READ_LAST, 4'd0, 4'd0, 32'h0, 32'h0);
        send(dbst_pkg::KIND_END, 4'd0, 4'd0, 32'h0, 32'h0);
        send(KIND_SPARE_6, 4'd0, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(KIND_SPARE_7, 4'd15, 4'd15, 32'h0, 32'h0);
        send(dbst_pkg::KIND_RESET_ONE, 4'd0, 4'd15, 32'h0, 32'h0);
        send(dbst_pkg::KIND_READ_LAST, 4'd0, 4'd15, 32'h0, 32'h0);
    endtask

    task automatic directed_disabled();
        send(dbst_pkg::KIND_END, 4'd15, 4'd15, 32'h0, 32'h0);
        send(dbst_pkg::KIND_READ_LAST, 4'd15, 4'd15, 32'h0, 32'h0);
        send(dbst_pkg::KIND_SET, 4'd15, 4'd15, 32'h0, 32'h1234_5678);
        send(dbst_pkg::KIND_RESET_ONE, 4'd15, 4'd15, 32'h0, 32'h0);
        send(dbst_pkg::KIND_RESET_ALL, 4'd0, 4'd0, 32'h0, 32'h0);
        send(dbst_pkg::KIND_BEGIN, 4'd0, 4'd0, 32'hFFFF_FFFF, 32'h0);
        send(dbst_pkg::KIND_READ_LAST, 4'd0, 4'd0, 32'h0, 32'h0);
    endtask

    task automatic random_traffic(int count);
        int          done;
        logic [3:0]  set_idx;
        logic [3:0]  slot_idx;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                send(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), $urandom, $urandom);
                done++;
            end
            else
            begin
                set_idx = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
                slot_idx = 4'($urandom_range(0, 15));
                if ($urandom_range(0, 15) == 0)
                    free_run_us = $urandom;
                else
                    free_run_us = free_run_us + $urandom_range(1, 5000);
                send(dbst_pkg::KIND_BEGIN, set_idx, slot_idx, free_run_us, $urandom);
                done++;
                if ($urandom_range(0, 4) == 0)
                begin
                    send(dbst_pkg::KIND_SET, set_idx, slot_idx, $urandom, $urandom);
                    done++;
                end
                if ($urandom_range(0, 7) == 0)
                    free_run_us = free_run_us + $urandom;
                else
                    free_run_us = free_run_us + $urandom_range(0, 100000);
                send(dbst_pkg::KIND_END, set_idx, slot_idx, free_run_us, $urandom);
                done++;
                if ($urandom_range(0, 1) == 0)
                begin
                    send(dbst_pkg::KIND_READ_LAST, set_idx, slot_idx, $urandom, $urandom);
                    done++;
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    send(dbst_pkg::KIND_RESET_ONE, set_idx, slot_idx, $urandom, $urandom);
                    done++;
                end
                if ($urandom_range(0, 11) == 0)
                begin
                    send(dbst_pkg::KIND_RESET_ALL, 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), $urandom, $urandom);
                    done++;
                end
            end
        end
    endtask

    initial
    begin
        timer_tracker = new();
        in_gap_rate = 0;
        out_stall_rate = 0;
        quiet_cycles = 0;
        free_run_us = $urandom;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= dbst_pkg::KIND_BEGIN;
        set_index <= '0;
        slot_index <= '0;
        now_us <= '0;
        write_value <= '0;
        cfg_we <= 1'b0;
        cfg_index <= dbst_pkg::CFG_ENABLED;
        cfg_data <= '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        in_gap_rate = 2;
        out_stall_rate = 2;
        apply_settings(1'b1, 5'd16);
        directed_enabled();
        random_traffic(300);
        drain_and_settle();

        in_gap_rate = 3;
        out_stall_rate = 3;
        apply_settings(1'b0, 5'd5);
        directed_disabled();
        random_traffic(150);
        drain_and_settle();

        in_gap_rate = 4;
        out_stall_rate = 1;
        apply_settings(1'b1, 5'd0);
        random_traffic(250);
        drain_and_settle();

        in_gap_rate = 0;
        out_stall_rate = 4;
        apply_settings(1'b1, 5'd31);
        random_traffic(250);
        drain_and_settle();

        in_gap_rate = 3;
        out_stall_rate = 0;
        apply_settings(1'b1, 5'd1);
        random_traffic(200);
        drain_and_settle();

        in_gap_rate = 0;
        out_stall_rate = 0;
        apply_settings(1'b1, 5'($urandom_range(1, 16)));
        random_traffic(300);
        drain_and_settle();

        if (timer_tracker.errors == 0 && timer_tracker.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== double_buffered_slot_timer_bank.f =====
hdl/dbst_pkg.sv
hdl/dbst_ctrl.sv
hdl/dbst_datapath.sv
hdl/double_buffered_slot_timer_bank.sv
hdl/dbst_checker.sv
tb/tb_double_buffered_slot_timer_bank.sv
